>>> rtl/ihss_pkg.sv
// Shared types and constants for the image header size sniffer.
// Used by the stream interfaces' users, the walker, the evaluator and the top level.
`default_nettype none

package ihss_pkg;

    // Header capture: only the first bytes of a file are ever inspected
    localparam int HDR_BYTES      = 30;
    localparam int HDR_IDX_BITS   = $clog2(HDR_BYTES);
    localparam int COUNT_BITS_DEF = 32;

    // Minimum file sizes before a format's header fields may be read
    localparam int MIN_GUESS = 2;
    localparam int MIN_JPEG  = 4;
    localparam int MIN_GIF   = 10;
    localparam int MIN_PNG   = 24;
    localparam int MIN_WEBP  = 30;

    // Result format codes
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_PNG  = 3'd1;
    localparam logic [2:0] FMT_JPEG = 3'd2;
    localparam logic [2:0] FMT_GIF  = 3'd3;
    localparam logic [2:0] FMT_WEBP = 3'd4;

    // Extension guess codes
    localparam logic [1:0] GUESS_JPEG = 2'd0;
    localparam logic [1:0] GUESS_PNG  = 2'd1;
    localparam logic [1:0] GUESS_GIF  = 2'd2;
    localparam logic [1:0] GUESS_WEBP = 2'd3;

    // JPEG marker bytes
    localparam logic [7:0] MK_PREFIX    = 8'hff;
    localparam logic [7:0] MK_SOI       = 8'hd8;
    localparam logic [7:0] MK_RST_FIRST = 8'hd0;
    localparam logic [7:0] MK_EOI       = 8'hd9;
    localparam logic [7:0] MK_SOF_FIRST = 8'hc0;
    localparam logic [7:0] MK_SOF_LAST  = 8'hcf;
    localparam logic [7:0] MK_DHT       = 8'hc4;
    localparam logic [7:0] MK_JPG       = 8'hc8;
    localparam logic [7:0] MK_DAC       = 8'hcc;

    // Signatures and chunk tags
    localparam logic [63:0] PNG_SIG  = 64'h89504e470d0a1a0a;
    localparam logic [47:0] GIF87A   = "GIF87a";
    localparam logic [47:0] GIF89A   = "GIF89a";
    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WEBP = "WEBP";
    localparam logic [31:0] TAG_VP8X = "VP8X";
    localparam logic [31:0] TAG_VP8  = "VP8 ";
    localparam logic [31:0] TAG_VP8L = "VP8L";
    localparam logic [15:0] VP8_DIM_MASK = 16'h3fff;

    // JPEG segment walker phases
    typedef enum logic [2:0] {
        PH_SCAN,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_FRAME,
        PH_DONE,
        PH_STOP
    } t_phase;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    // Everything the evaluator needs about one finished file
    typedef struct packed {
        t_hdr        hdr;
        logic        ge_guess;
        logic        ge_jpeg;
        logic        ge_gif;
        logic        ge_png;
        logic        ge_webp;
        logic        jpeg_hit;
        logic [15:0] jpeg_w;
        logic [15:0] jpeg_h;
    } t_snap;

endpackage

`default_nettype wire

>>> rtl/ihss_if.sv
// Valid/ready stream interfaces for the image header size sniffer.
// Byte requests in, size results out; no dependencies.
`default_nettype none

interface ihss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ihss_size_if;
    logic        valid;
    logic        ready;
    logic        size_found;
    logic [2:0]  image_format;
    logic [30:0] pixel_width;
    logic [30:0] pixel_height;
    logic [1:0]  guessed_format;

    modport source (output valid, output size_found, output image_format,
                    output pixel_width, output pixel_height, output guessed_format,
                    input ready);
    modport sink   (input valid, input size_found, input image_format,
                    input pixel_width, input pixel_height, input guessed_format,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/ihss_walker.sv
// Per-byte state: byte count, header capture and JPEG segment walker.
// Produces the file snapshot on the final byte; depends on ihss_pkg.
`default_nettype none

module ihss_walker
    import ihss_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output t_snap           o_snap
);

    logic [COUNT_BITS-1:0] r_count;
    t_hdr                  r_hdr;
    t_phase                r_phase;
    logic [7:0]            r_marker;
    logic [15:0]           r_seg_len;
    logic [15:0]           r_seg_pos;
    logic [15:0]           r_frame_h;
    logic [15:0]           r_frame_w;
    logic [COUNT_BITS:0]   r_needed;
    logic                  r_seen;

    logic [COUNT_BITS-1:0] n_count;
    t_hdr                  n_hdr;
    t_phase                n_phase;
    logic [7:0]            n_marker;
    logic [15:0]           n_seg_len;
    logic [15:0]           n_seg_pos;
    logic [15:0]           n_frame_h;
    logic [15:0]           n_frame_w;
    logic [COUNT_BITS:0]   n_needed;
    logic                  n_seen;

    logic        walk_en;
    logic        hdr_wr;
    logic [15:0] len_full;
    logic [15:0] len_ext;
    logic [15:0] pos_inc;
    logic        marker_sof;
    logic        marker_alone;

    // Saturating byte count; the walker starts at the third byte
    assign n_count = (r_count == '1) ? r_count : r_count + 1'b1;
    assign walk_en = (r_count[COUNT_BITS-1:1] != '0);

    // Capture header bytes at the current position
    assign hdr_wr = i_take && (r_count < COUNT_BITS'(HDR_BYTES));
    always_comb begin
        n_hdr = r_hdr;
        if (hdr_wr) begin
            n_hdr[r_count[HDR_IDX_BITS-1:0]] = i_data_byte;
        end
    end

    // Marker classes
    assign marker_sof = (r_marker >= MK_SOF_FIRST) && (r_marker <= MK_SOF_LAST)
                     && (r_marker != MK_DHT) && (r_marker != MK_JPG) && (r_marker != MK_DAC);
    assign marker_alone = (i_data_byte >= MK_RST_FIRST) && (i_data_byte <= MK_EOI);

    assign len_full = {r_seg_len[15:8], i_data_byte};
    // Frame needs the larger of offset+10 and offset+2+length (idx is offset+3)
    assign len_ext  = (len_full > 16'd8) ? len_full - 16'd1 : 16'd7;
    assign pos_inc  = r_seg_pos + 16'd1;

    // Advance the segment walker
    always_comb begin
        n_phase   = r_phase;
        n_marker  = r_marker;
        n_seg_len = r_seg_len;
        n_seg_pos = r_seg_pos;
        n_frame_h = r_frame_h;
        n_frame_w = r_frame_w;
        n_needed  = r_needed;
        n_seen    = r_seen;
        if (walk_en) begin
            unique case (r_phase)
                PH_SCAN: begin
                    if (i_data_byte == MK_PREFIX) begin
                        n_phase = PH_MARKER;
                    end
                end
                PH_MARKER: begin
                    n_marker = i_data_byte;
                    n_phase  = marker_alone ? PH_SCAN : PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_seg_len = {i_data_byte, 8'h00};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_seg_len = len_full;
                    if (len_full < 16'd2) begin
                        n_phase = PH_STOP;
                    end else if (marker_sof) begin
                        if (len_full < 16'd7) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_needed  = {1'b0, r_count} + (COUNT_BITS+1)'(len_ext);
                            n_seg_pos = 16'd0;
                            n_phase   = PH_FRAME;
                        end
                    end else if (len_full == 16'd2) begin
                        n_phase = PH_SCAN;
                    end else begin
                        n_seg_pos = 16'd2;
                        n_phase   = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_seg_pos = pos_inc;
                    if (pos_inc >= r_seg_len) begin
                        n_phase = PH_SCAN;
                    end
                end
                PH_FRAME: begin
                    n_seg_pos = pos_inc;
                    priority if (r_seg_pos == 16'd1) begin
                        n_frame_h = {i_data_byte, 8'h00};
                    end else if (r_seg_pos == 16'd2) begin
                        n_frame_h = {r_frame_h[15:8], i_data_byte};
                    end else if (r_seg_pos == 16'd3) begin
                        n_frame_w = {i_data_byte, 8'h00};
                    end else if (r_seg_pos == 16'd4) begin
                        n_frame_w = {r_frame_w[15:8], i_data_byte};
                        n_seen    = 1'b1;
                        n_phase   = PH_DONE;
                    end else begin
                        n_frame_h = r_frame_h;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
    end

    // Hold header bytes; they are only read below the byte count
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_hdr <= n_hdr;
        end
    end

    // Update walker state, drop back to reset after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_phase   <= PH_SCAN;
            r_marker  <= '0;
            r_seg_len <= '0;
            r_seg_pos <= '0;
            r_frame_h <= '0;
            r_frame_w <= '0;
            r_needed  <= '0;
            r_seen    <= 1'b0;
        end else if (i_take) begin
            if (i_final_byte) begin
                r_count   <= '0;
                r_phase   <= PH_SCAN;
                r_marker  <= '0;
                r_seg_len <= '0;
                r_seg_pos <= '0;
                r_frame_h <= '0;
                r_frame_w <= '0;
                r_needed  <= '0;
                r_seen    <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_phase   <= n_phase;
                r_marker  <= n_marker;
                r_seg_len <= n_seg_len;
                r_seg_pos <= n_seg_pos;
                r_frame_h <= n_frame_h;
                r_frame_w <= n_frame_w;
                r_needed  <= n_needed;
                r_seen    <= n_seen;
            end
        end
    end

    // Snapshot of the file as it stands after this byte
    always_comb begin
        o_snap.hdr      = n_hdr;
        o_snap.ge_guess = (r_count >= COUNT_BITS'(MIN_GUESS - 1));
        o_snap.ge_jpeg  = (r_count >= COUNT_BITS'(MIN_JPEG - 1));
        o_snap.ge_gif   = (r_count >= COUNT_BITS'(MIN_GIF - 1));
        o_snap.ge_png   = (r_count >= COUNT_BITS'(MIN_PNG - 1));
        o_snap.ge_webp  = (r_count >= COUNT_BITS'(MIN_WEBP - 1));
        // The frame length is fixed before the frame is seen, so r_needed is current
        o_snap.jpeg_hit = n_seen && ({1'b0, n_count} >= r_needed)
                       && (n_frame_w != 16'd0) && (n_frame_h != 16'd0);
        o_snap.jpeg_w   = n_frame_w;
        o_snap.jpeg_h   = n_frame_h;
    end

endmodule

`default_nettype wire

>>> rtl/ihss_eval.sv
// Snapshot register, format decision and output result register.
// Drives the result stream; depends on ihss_pkg and ihss_if.
`default_nettype none

module ihss_eval
    import ihss_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_snap   i_snap,
    output logic         o_can_load,
    ihss_size_if.source  o_out
);

    logic        r_snap_valid;
    t_snap       r_snap;
    logic        r_out_valid;
    logic        r_found;
    logic [2:0]  r_format;
    logic [30:0] r_width;
    logic [30:0] r_height;
    logic [1:0]  r_guess;

    logic        n_found;
    logic [2:0]  n_format;
    logic [30:0] n_width;
    logic [30:0] n_height;
    logic [1:0]  n_guess;

    logic        advance;
    t_hdr        h;
    logic [31:0] png_w;
    logic [31:0] png_h;
    logic        png_ok;
    logic        jpeg_soi;
    logic        jpeg_ok;
    logic [47:0] gif_sig;
    logic [15:0] gif_w;
    logic [15:0] gif_h;
    logic        gif_ok;
    logic        riff_ok;
    logic [31:0] chunk;
    logic        is_vp8x;
    logic        is_vp8;
    logic        is_vp8l;
    logic [24:0] vp8x_w;
    logic [24:0] vp8x_h;
    logic [15:0] vp8_w;
    logic [15:0] vp8_h;
    logic [31:0] vp8l_bits;
    logic [14:0] vp8l_w;
    logic [14:0] vp8l_h;
    logic        webp_ok;
    logic [24:0] webp_w;
    logic [24:0] webp_h;

    // Move the snapshot out when the result register is free
    assign advance    = !r_out_valid || o_out.ready;
    assign o_can_load = !r_snap_valid || advance;

    assign h = r_snap.hdr;

    // PNG: signature and big-endian 31-bit dimensions
    assign png_w  = {h[16], h[17], h[18], h[19]};
    assign png_h  = {h[20], h[21], h[22], h[23]};
    assign png_ok = r_snap.ge_png
                 && ({h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]} == PNG_SIG)
                 && (png_w != 32'd0) && (png_h != 32'd0) && !png_w[31] && !png_h[31];

    // JPEG: start-of-image plus a frame captured by the walker
    assign jpeg_soi = (h[0] == MK_PREFIX) && (h[1] == MK_SOI);
    assign jpeg_ok  = r_snap.ge_jpeg && jpeg_soi && r_snap.jpeg_hit;

    // GIF: either version tag, little-endian 16-bit dimensions
    assign gif_sig = {h[0], h[1], h[2], h[3], h[4], h[5]};
    assign gif_w   = {h[7], h[6]};
    assign gif_h   = {h[9], h[8]};
    assign gif_ok  = r_snap.ge_gif && ((gif_sig == GIF87A) || (gif_sig == GIF89A))
                  && (gif_w != 16'd0) && (gif_h != 16'd0);

    // WebP: container check, then one of the three chunk kinds
    assign riff_ok = r_snap.ge_webp && ({h[0], h[1], h[2], h[3]} == TAG_RIFF)
                  && ({h[8], h[9], h[10], h[11]} == TAG_WEBP);
    assign chunk   = {h[12], h[13], h[14], h[15]};
    assign is_vp8x = (chunk == TAG_VP8X);
    assign is_vp8  = (chunk == TAG_VP8);
    assign is_vp8l = (chunk == TAG_VP8L);

    assign vp8x_w    = {1'b0, h[26], h[25], h[24]} + 25'd1;
    assign vp8x_h    = {1'b0, h[29], h[28], h[27]} + 25'd1;
    assign vp8_w     = {h[27], h[26]} & VP8_DIM_MASK;
    assign vp8_h     = {h[29], h[28]} & VP8_DIM_MASK;
    assign vp8l_bits = {h[24], h[23], h[22], h[21]};
    assign vp8l_w    = {1'b0, vp8l_bits[13:0]} + 15'd1;
    assign vp8l_h    = {1'b0, vp8l_bits[27:14]} + 15'd1;

    assign webp_ok = riff_ok
                  && (is_vp8x || (is_vp8 && (vp8_w != 16'd0) && (vp8_h != 16'd0)) || is_vp8l);

    always_comb begin
        priority if (is_vp8x) begin
            webp_w = vp8x_w;
            webp_h = vp8x_h;
        end else if (is_vp8) begin
            webp_w = 25'(vp8_w);
            webp_h = 25'(vp8_h);
        end else begin
            webp_w = 25'(vp8l_w);
            webp_h = 25'(vp8l_h);
        end
    end

    // Pick the size by format priority
    always_comb begin
        priority if (png_ok) begin
            n_format = FMT_PNG;
            n_width  = png_w[30:0];
            n_height = png_h[30:0];
        end else if (jpeg_ok) begin
            n_format = FMT_JPEG;
            n_width  = 31'(r_snap.jpeg_w);
            n_height = 31'(r_snap.jpeg_h);
        end else if (gif_ok) begin
            n_format = FMT_GIF;
            n_width  = 31'(gif_w);
            n_height = 31'(gif_h);
        end else if (webp_ok) begin
            n_format = FMT_WEBP;
            n_width  = 31'(webp_w);
            n_height = 31'(webp_h);
        end else begin
            n_format = FMT_NONE;
            n_width  = '0;
            n_height = '0;
        end
        n_found = (n_format != FMT_NONE);
    end

    // Extension guess, PNG when nothing fits
    always_comb begin
        priority if (r_snap.ge_guess && jpeg_soi) begin
            n_guess = GUESS_JPEG;
        end else if (png_ok) begin
            n_guess = GUESS_PNG;
        end else if (gif_ok) begin
            n_guess = GUESS_GIF;
        end else if (webp_ok) begin
            n_guess = GUESS_WEBP;
        end else begin
            n_guess = GUESS_PNG;
        end
    end

    // Valid flags for the snapshot and result stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_can_load) begin
                r_snap_valid <= i_load;
            end
            if (advance) begin
                r_out_valid <= r_snap_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_snap <= i_snap;
        end
        if (advance && r_snap_valid) begin
            r_found  <= n_found;
            r_format <= n_format;
            r_width  <= n_width;
            r_height <= n_height;
            r_guess  <= n_guess;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.size_found     = r_found;
    assign o_out.image_format   = r_format;
    assign o_out.pixel_width    = r_width;
    assign o_out.pixel_height   = r_height;
    assign o_out.guessed_format = r_guess;

endmodule

`default_nettype wire

>>> rtl/image_header_size_sniffer_unit.sv
// Image header size sniffer. Bytes of one image file stream in on i_in, one request per
// byte, the last one flagged by final_byte; one size result per file leaves on o_out.
// The block takes one byte every cycle while i_in.ready is high. The snapshot register
// loads at the edge that accepts a file's final byte, and the result register takes the
// decision over from it as soon as o_out is free; files of any length, down to a
// single byte, may follow one another without gaps. i_in.ready drops only while both
// the snapshot and the result register hold results and o_out is stalled. After reset
// the block is ready at once; no memory needs clearing.
// Depends on ihss_pkg, ihss_if, ihss_walker and ihss_eval.
`default_nettype none

module image_header_size_sniffer_unit
    import ihss_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ihss_byte_if.sink   i_in,
    ihss_size_if.source o_out
);

    logic  take;
    logic  can_load;
    t_snap snap;

    // Accept a byte whenever the snapshot stage has room
    assign i_in.ready = can_load;
    assign take       = i_in.valid && can_load;

    ihss_walker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_in.data_byte),
        .i_final_byte (i_in.final_byte),
        .o_snap       (snap)
    );

    ihss_eval u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && i_in.final_byte),
        .i_snap     (snap),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

>>> tb/image_header_size_sniffer_unit_test.sv
// Self-checking test of the image header size sniffer: streams whole image files
// (PNG, JPEG, GIF, WebP, noise) through valid/ready with random idling on both sides.
// Depends on ihss_pkg, ihss_if and image_header_size_sniffer_unit.

module image_header_size_sniffer_unit_test;
    import ihss_pkg::*;

    localparam int          CYCLE_LIMIT    = 500000;
    localparam int          SHOWN_ERRORS   = 10;
    localparam int          RANDOM_FILES   = 4;
    localparam int          RANDOM_BYTES   = 60;
    localparam int          TAIL_CYCLES    = 4;
    localparam logic [31:0] TAG_IHDR       = "IHDR";
    localparam logic [31:0] TAG_ALPH       = "ALPH";
    localparam logic [31:0] IHDR_LEN       = 32'd13;
    localparam logic [7:0]  MK_APP0        = 8'he0;
    localparam logic [7:0]  SAMPLE_PREC    = 8'd8;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic        found;
        logic [2:0]  fmt;
        logic [30:0] width;
        logic [30:0] height;
        logic [1:0]  guess;
    } t_size_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ihss_byte_if byte_bus ();
    ihss_size_if size_bus ();

    image_header_size_sniffer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_bus),
        .o_out   (size_bus)
    );

    always #5 i_clk = ~i_clk;

    // Predicted sniffer state for the file in flight
    logic [COUNT_BITS_DEF-1:0] bytes_seen;
    logic [7:0]                head_bytes [HDR_BYTES];
    t_phase                    walk_phase;
    logic [7:0]                walk_marker;
    logic [15:0]               walk_len;
    logic [15:0]               walk_pos;
    logic [15:0]               sof_height;
    logic [15:0]               sof_width;
    logic [63:0]               sof_end;
    logic                      sof_valid;

    t_size_res   pending_sizes [$];
    logic [7:0]  file_buf [$];
    t_size_res   got_size;
    t_size_res   want_size;
    int          fail_count = 0;
    int          files_sent = 0;
    int          sizes_seen = 0;
    int          cycle_no   = 0;
    int          rx_hold    = 0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task clear_sniff();
        bytes_seen  = '0;
        for (int i = 0; i < HDR_BYTES; i++) head_bytes[i] = '0;
        walk_phase  = PH_SCAN;
        walk_marker = '0;
        walk_len    = '0;
        walk_pos    = '0;
        sof_height  = '0;
        sof_width   = '0;
        sof_end     = '0;
        sof_valid   = 1'b0;
    endtask

    // Advance the JPEG segment walker by one byte at file offset pos
    task walk_byte(input logic [7:0] b, input logic [63:0] pos);
        logic        frame_mark;
        logic [63:0] hdr_end;
        logic [63:0] seg_end;
        frame_mark = walk_marker >= MK_SOF_FIRST && walk_marker <= MK_SOF_LAST &&
                     walk_marker != MK_DHT && walk_marker != MK_JPG && walk_marker != MK_DAC;
        case (walk_phase)
            PH_SCAN: begin
                if (b == MK_PREFIX) walk_phase = PH_MARKER;
            end
            PH_MARKER: begin
                walk_marker = b;
                walk_phase  = (b >= MK_RST_FIRST && b <= MK_EOI) ? PH_SCAN : PH_LEN_HI;
            end
            PH_LEN_HI: begin
                walk_len   = {b, 8'h00};
                walk_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                walk_len = walk_len | {8'h00, b};
                if (walk_len < 16'd2) begin
                    walk_phase = PH_STOP;
                end else if (frame_mark) begin
                    if (walk_len < 16'd7) begin
                        walk_phase = PH_STOP;
                    end else begin
                        // frame must fit both its fixed fields and its declared length
                        hdr_end    = pos + 64'd7;
                        seg_end    = pos - 64'd1 + {48'd0, walk_len};
                        sof_end    = (hdr_end > seg_end) ? hdr_end : seg_end;
                        walk_pos   = '0;
                        walk_phase = PH_FRAME;
                    end
                end else if (walk_len == 16'd2) begin
                    walk_phase = PH_SCAN;
                end else begin
                    walk_pos   = 16'd2;
                    walk_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                walk_pos = walk_pos + 16'd1;
                if (walk_pos >= walk_len) walk_phase = PH_SCAN;
            end
            PH_FRAME: begin
                // precision, then height and width big-endian
                case (walk_pos)
                    16'd1: sof_height = {b, 8'h00};
                    16'd2: sof_height = sof_height | {8'h00, b};
                    16'd3: sof_width  = {b, 8'h00};
                    16'd4: begin
                        sof_width  = sof_width | {8'h00, b};
                        sof_valid  = 1'b1;
                        walk_phase = PH_DONE;
                    end
                    default: ;
                endcase
                walk_pos = walk_pos + 16'd1;
            end
            default: ;
        endcase
    endtask

    function automatic logic png_dims(input logic [63:0] s, output logic [30:0] w,
                                      output logic [30:0] h);
        logic [31:0] a;
        logic [31:0] c;
        w = '0;
        h = '0;
        if (s < MIN_PNG) return 1'b0;
        for (int i = 0; i < 8; i++)
            if (head_bytes[i] != PNG_SIG[63-8*i -: 8]) return 1'b0;
        a = {head_bytes[16], head_bytes[17], head_bytes[18], head_bytes[19]};
        c = {head_bytes[20], head_bytes[21], head_bytes[22], head_bytes[23]};
        if (a == '0 || c == '0 || a[31] || c[31]) return 1'b0;
        w = a[30:0];
        h = c[30:0];
        return 1'b1;
    endfunction

    function automatic logic jpeg_dims(input logic [63:0] s, output logic [30:0] w,
                                       output logic [30:0] h);
        w = '0;
        h = '0;
        if (s < MIN_JPEG || head_bytes[0] != MK_PREFIX || head_bytes[1] != MK_SOI)
            return 1'b0;
        if (!sof_valid || s < sof_end) return 1'b0;
        if (sof_width == '0 || sof_height == '0) return 1'b0;
        w = 31'(sof_width);
        h = 31'(sof_height);
        return 1'b1;
    endfunction

    function automatic logic gif_dims(input logic [63:0] s, output logic [30:0] w,
                                      output logic [30:0] h);
        logic [47:0] sig;
        logic [15:0] a;
        logic [15:0] c;
        w = '0;
        h = '0;
        sig = {head_bytes[0], head_bytes[1], head_bytes[2],
               head_bytes[3], head_bytes[4], head_bytes[5]};
        if (s < MIN_GIF || (sig != GIF87A && sig != GIF89A)) return 1'b0;
        a = {head_bytes[7], head_bytes[6]};
        c = {head_bytes[9], head_bytes[8]};
        if (a == '0 || c == '0) return 1'b0;
        w = 31'(a);
        h = 31'(c);
        return 1'b1;
    endfunction

    function automatic logic webp_dims(input logic [63:0] s, output logic [30:0] w,
                                       output logic [30:0] h);
        logic [31:0] chunk;
        logic [31:0] bits;
        logic [15:0] a;
        logic [15:0] c;
        w = '0;
        h = '0;
        if (s < MIN_WEBP) return 1'b0;
        if ({head_bytes[0], head_bytes[1], head_bytes[2], head_bytes[3]} != TAG_RIFF ||
            {head_bytes[8], head_bytes[9], head_bytes[10], head_bytes[11]} != TAG_WEBP)
            return 1'b0;
        chunk = {head_bytes[12], head_bytes[13], head_bytes[14], head_bytes[15]};
        if (chunk == TAG_VP8X) begin
            w = 31'({head_bytes[26], head_bytes[25], head_bytes[24]}) + 31'd1;
            h = 31'({head_bytes[29], head_bytes[28], head_bytes[27]}) + 31'd1;
            return 1'b1;
        end
        if (chunk == TAG_VP8) begin
            // little-endian 14-bit fields, scale bits dropped
            a = {head_bytes[27], head_bytes[26]} & VP8_DIM_MASK;
            c = {head_bytes[29], head_bytes[28]} & VP8_DIM_MASK;
            if (a == '0 || c == '0) return 1'b0;
            w = 31'(a);
            h = 31'(c);
            return 1'b1;
        end
        if (chunk == TAG_VP8L) begin
            bits = {head_bytes[24], head_bytes[23], head_bytes[22], head_bytes[21]};
            w = 31'(bits[13:0]) + 31'd1;
            h = 31'(bits[27:14]) + 31'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Fold one accepted byte into the prediction; queue a size on the last byte
    task sniff_byte(input logic [7:0] b, input logic last);
        logic [63:0] pos;
        logic [63:0] s;
        logic [30:0] w;
        logic [30:0] h;
        logic [30:0] tw;
        logic [30:0] th;
        t_size_res   res;
        pos = 64'(bytes_seen);
        if (pos < HDR_BYTES) head_bytes[pos] = b;
        if (pos >= 64'd2) walk_byte(b, pos);
        if (bytes_seen != COUNT_TOP) bytes_seen = bytes_seen + 1'b1;
        if (last) begin
            s   = 64'(bytes_seen);
            res = '0;
            if (png_dims(s, w, h)) res.fmt = FMT_PNG;
            else if (jpeg_dims(s, w, h)) res.fmt = FMT_JPEG;
            else if (gif_dims(s, w, h)) res.fmt = FMT_GIF;
            else if (webp_dims(s, w, h)) res.fmt = FMT_WEBP;
            if (res.fmt != FMT_NONE) begin
                res.found  = 1'b1;
                res.width  = w;
                res.height = h;
            end
            if (s >= MIN_GUESS && head_bytes[0] == MK_PREFIX && head_bytes[1] == MK_SOI)
                res.guess = GUESS_JPEG;
            else if (png_dims(s, tw, th)) res.guess = GUESS_PNG;
            else if (gif_dims(s, tw, th)) res.guess = GUESS_GIF;
            else if (webp_dims(s, tw, th)) res.guess = GUESS_WEBP;
            else res.guess = GUESS_PNG;
            pending_sizes.push_back(res);
            clear_sniff();
        end
    endtask

    // Hold one byte request until accepted, after a random idle gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) byte_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        byte_bus.valid      <= 1'b1;
        byte_bus.data_byte  <= b;
        byte_bus.final_byte <= last;
        do @(posedge i_clk); while (!byte_bus.ready);
        sniff_byte(b, last);
    endtask

    task automatic send_file();
        int n;
        n = file_buf.size();
        for (int i = 0; i < n; i++) send_byte(file_buf[i], i == n - 1);
        file_buf.delete();
        files_sent++;
    endtask

    // Drop valid and hold off until every predicted size has come back
    task automatic wait_all_sizes();
        @(negedge i_clk) byte_bus.valid <= 1'b0;
        while (pending_sizes.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_rand(input int n);
        repeat (n) file_buf.push_back(8'($urandom));
    endtask

    task automatic put16be(input logic [15:0] v);
        file_buf.push_back(v[15:8]);
        file_buf.push_back(v[7:0]);
    endtask

    task automatic put32be(input logic [31:0] v);
        put16be(v[31:16]);
        put16be(v[15:0]);
    endtask

    task automatic write_le(input logic [63:0] v, input int pos, input int n);
        for (int i = 0; i < n; i++)
            if (pos + i < file_buf.size()) file_buf[pos + i] = v[8*i +: 8];
    endtask

    task automatic add_png(input logic [31:0] w, input logic [31:0] h, input int extra);
        for (int i = 0; i < 8; i++) file_buf.push_back(PNG_SIG[63-8*i -: 8]);
        put32be(IHDR_LEN);
        put32be(TAG_IHDR);
        put32be(w);
        put32be(h);
        put_rand(extra);
    endtask

    task automatic add_gif(input logic late, input logic [15:0] w, input logic [15:0] h,
                           input int extra);
        logic [47:0] sig;
        sig = late ? GIF89A : GIF87A;
        for (int i = 0; i < 6; i++) file_buf.push_back(sig[47-8*i -: 8]);
        file_buf.push_back(w[7:0]);
        file_buf.push_back(w[15:8]);
        file_buf.push_back(h[7:0]);
        file_buf.push_back(h[15:8]);
        put_rand(extra);
    endtask

    // RIFF container with a chunk tag; fields are patched in by the caller
    task automatic add_webp(input logic [31:0] chunk, input int extra);
        put32be(TAG_RIFF);
        put_rand(4);
        put32be(TAG_WEBP);
        put32be(chunk);
        put_rand(14 + extra);
    endtask

    // SOI, a few random segments, markers and stray bytes, then one frame header and EOI
    task automatic add_jpeg(input logic [7:0] frame_mark, input logic [15:0] frame_len,
                            input logic [15:0] h, input logic [15:0] w, input int junk);
        int n;
        file_buf.push_back(MK_PREFIX);
        file_buf.push_back(MK_SOI);
        repeat (junk) begin
            case ($urandom_range(0, 3))
                0: begin
                    n = $urandom_range(2, 12);
                    file_buf.push_back(MK_PREFIX);
                    file_buf.push_back(MK_APP0 + 8'($urandom_range(0, 15)));
                    put16be(16'(n));
                    put_rand(n - 2);
                end
                1: begin
                    file_buf.push_back(MK_PREFIX);
                    file_buf.push_back(MK_RST_FIRST + 8'($urandom_range(0, 9)));
                end
                2: file_buf.push_back(8'($urandom_range(0, 254)));
                default: begin
                    n = $urandom_range(2, 8);
                    file_buf.push_back(MK_PREFIX);
                    file_buf.push_back(MK_DHT);
                    put16be(16'(n));
                    put_rand(n - 2);
                end
            endcase
        end
        file_buf.push_back(MK_PREFIX);
        file_buf.push_back(frame_mark);
        put16be(frame_len);
        file_buf.push_back(SAMPLE_PREC);
        put16be(h);
        put16be(w);
        n = (frame_len > 16'd7) ? int'(frame_len) - 7 : 0;
        put_rand((n > 16) ? 16 : n);
        file_buf.push_back(MK_PREFIX);
        file_buf.push_back(MK_EOI);
    endtask

    task automatic shorten_file(input int n);
        while (file_buf.size() > n) file_buf.delete(file_buf.size() - 1);
    endtask

    function automatic logic [31:0] rand_dim32();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h8000_0000 | $urandom;
            2: return 32'h7fff_ffff;
            default: return $urandom_range(1, 100000);
        endcase
    endfunction

    function automatic logic [15:0] rand_dim16();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'hffff;
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic logic [15:0] rand_frame_len();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 8));
            default: return 16'd8 + 16'(3 * $urandom_range(1, 3));
        endcase
    endfunction

    task automatic test_png_headers();
        add_png(32'd1, 32'd1, 0);
        send_file();
        add_png(32'h7fff_ffff, 32'h7fff_ffff, 5);
        send_file();
        add_png(32'h8000_0000, 32'd5, 0);
        send_file();
        add_png(32'd0, 32'd7, 0);
        send_file();
        // one byte short of the height field
        add_png(32'd100, 32'd200, 0);
        shorten_file(MIN_PNG - 1);
        send_file();
    endtask

    task automatic test_jpeg_walk();
        add_jpeg(MK_SOF_FIRST, 16'd17, 16'd480, 16'd640, 3);
        send_file();
        add_jpeg(MK_SOF_LAST, 16'd7, 16'hffff, 16'hffff, 0);
        send_file();
        // table segment is skipped, not captured
        add_jpeg(MK_DHT, 16'd17, 16'd1, 16'd1, 1);
        send_file();
        // segment length below two stops the walk
        add_jpeg(MK_SOF_FIRST, 16'd1, 16'd8, 16'd8, 0);
        send_file();
        // frame header too short to hold the size
        add_jpeg(MK_SOF_FIRST + 8'd2, 16'd6, 16'd8, 16'd8, 1);
        send_file();
        add_jpeg(MK_SOF_FIRST, 16'd17, 16'd0, 16'd100, 1);
        send_file();
        // declared frame runs past the end of the file
        add_jpeg(MK_SOF_FIRST, 16'h0400, 16'd10, 16'd20, 0);
        send_file();
        add_jpeg(MK_SOF_FIRST, 16'd17, 16'd3, 16'd4, 0);
        shorten_file(2);
        send_file();
        add_jpeg(MK_SOF_FIRST, 16'd17, 16'd3, 16'd4, 0);
        shorten_file(3);
        send_file();
    endtask

    task automatic test_gif_headers();
        add_gif(1'b0, 16'd1, 16'd1, 0);
        send_file();
        add_gif(1'b1, 16'hffff, 16'hffff, 3);
        send_file();
        add_gif(1'b1, 16'd5, 16'd0, 0);
        send_file();
        add_gif(1'b0, 16'd3, 16'd3, 0);
        shorten_file(MIN_GIF - 1);
        send_file();
    endtask

    task automatic test_webp_chunks();
        add_webp(TAG_VP8X, 0);
        write_le({16'h0, 24'hffffff, 24'hffffff}, 24, 6);
        send_file();
        // scale bits above the 14-bit size must be ignored
        add_webp(TAG_VP8, 2);
        write_le({32'h0, 16'hc123, 16'hffff}, 26, 4);
        send_file();
        add_webp(TAG_VP8, 0);
        write_le({32'h0, 16'h4000, 16'hc000}, 26, 4);
        send_file();
        add_webp(TAG_VP8L, 0);
        write_le(64'hffff_ffff, 21, 4);
        send_file();
        add_webp(TAG_ALPH, 0);
        send_file();
        add_webp(TAG_VP8X, 0);
        shorten_file(MIN_WEBP - 1);
        send_file();
    endtask

    task automatic test_odd_files();
        file_buf.push_back(8'h00);
        send_file();
        file_buf.push_back(8'hff);
        send_file();
        repeat (16) file_buf.push_back(MK_PREFIX);
        send_file();
        put_rand(12);
        send_file();
    endtask

    task automatic test_random_files();
        int nfiles;
        int nbytes;
        nfiles = 0;
        nbytes = 0;
        while (nfiles < RANDOM_FILES || nbytes < RANDOM_BYTES) begin
            tx_calm = ($urandom_range(0, 7) == 0);
            rx_calm = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0, 1: add_png(rand_dim32(), rand_dim32(), $urandom_range(0, 6));
                2, 3, 4: add_jpeg(MK_SOF_FIRST + 8'($urandom_range(0, 15)), rand_frame_len(),
                                  rand_dim16(), rand_dim16(), $urandom_range(0, 4));
                5: add_gif(1'($urandom_range(0, 1)), rand_dim16(), rand_dim16(),
                           $urandom_range(0, 4));
                6, 7: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            add_webp(TAG_VP8X, $urandom_range(0, 4));
                            write_le({$urandom, $urandom}, 24, 6);
                        end
                        1: begin
                            add_webp(TAG_VP8, $urandom_range(0, 4));
                            write_le(64'($urandom), 26, 4);
                        end
                        2: begin
                            add_webp(TAG_VP8L, $urandom_range(0, 4));
                            write_le(64'($urandom), 21, 4);
                        end
                        default: add_webp($urandom, $urandom_range(0, 4));
                    endcase
                end
                8: put_rand($urandom_range(1, 40));
                default: begin
                    // tiny files, often opening like a JPEG
                    if ($urandom_range(0, 1) == 1) begin
                        file_buf.push_back(MK_PREFIX);
                        file_buf.push_back(MK_SOI);
                    end
                    put_rand($urandom_range(1, 3));
                end
            endcase
            // cut short or damage some files
            if ($urandom_range(0, 5) == 0) shorten_file($urandom_range(1, file_buf.size()));
            if ($urandom_range(0, 5) == 0)
                file_buf[$urandom_range(0, file_buf.size() - 1)] = 8'($urandom);
            nbytes += file_buf.size();
            send_file();
            nfiles++;
            if (nfiles == RANDOM_FILES / 2) wait_all_sizes();
        end
    endtask

    // Result side: random stalls, with calm stretches
    always @(negedge i_clk) begin
        if (rx_hold == 0 && !rx_calm) rx_hold = pick_gap();
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            size_bus.ready <= 1'b0;
        end else begin
            size_bus.ready <= 1'b1;
        end
    end

    // Compare each accepted size result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && size_bus.valid === 1'b1 && size_bus.ready === 1'b1) begin
            got_size.found  = size_bus.size_found;
            got_size.fmt    = size_bus.image_format;
            got_size.width  = size_bus.pixel_width;
            got_size.height = size_bus.pixel_height;
            got_size.guess  = size_bus.guessed_format;
            if (pending_sizes.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("unexpected size result %0d: found=%0d fmt=%0d w=%0d h=%0d g=%0d",
                             sizes_seen, got_size.found, got_size.fmt, got_size.width,
                             got_size.height, got_size.guess);
            end else begin
                want_size = pending_sizes.pop_front();
                if (got_size !== want_size) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display({"size result %0d mismatch: expected found=%0d fmt=%0d ",
                                  "w=%0d h=%0d g=%0d, got found=%0d fmt=%0d w=%0d h=%0d g=%0d"},
                                 sizes_seen, want_size.found, want_size.fmt,
                                 want_size.width, want_size.height, want_size.guess,
                                 got_size.found, got_size.fmt, got_size.width,
                                 got_size.height, got_size.guess);
                end
            end
            sizes_seen++;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_no = cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        byte_bus.valid      = 1'b0;
        byte_bus.data_byte  = '0;
        byte_bus.final_byte = 1'b0;
        size_bus.ready      = 1'b0;
        clear_sniff();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_png_headers();
        test_jpeg_walk();
        test_gif_headers();
        test_webp_chunks();
        test_odd_files();
        test_random_files();

        wait_all_sizes();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_sizes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ihss_pkg.sv
rtl/ihss_if.sv
rtl/ihss_walker.sv
rtl/ihss_eval.sv
rtl/image_header_size_sniffer_unit.sv
tb/image_header_size_sniffer_unit_test.sv
